@@ hdl/mdec_pkg.sv @@
// Shared types, opcode constants and decode functions for the 8086 MOV decoder.
package mdec_pkg;

	// One input transaction: a raw code byte and the end-of-block mark
	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_block;
	} in_item_t;

	// One decoded MOV record
	typedef struct packed {
		logic        form;
		logic        wide;
		logic        reg_is_destination;
		logic [2:0]  reg_code;
		logic [2:0]  rm_code;
		logic [1:0]  mode;
		logic        direct_address;
		logic [1:0]  disp_bytes;
		logic [15:0] displacement;
		logic [15:0] immediate;
	} out_item_t;

	// Parse phase
	typedef enum logic [2:0] {
		PH_OPCODE  = 3'd0,
		PH_IMM_LO  = 3'd1,
		PH_IMM_HI  = 3'd2,
		PH_MODRM   = 3'd3,
		PH_DISP_LO = 3'd4,
		PH_DISP_HI = 3'd5
	} phase_t;

	// Record form codes
	localparam logic FORM_IMM_TO_REG = 1'b0;
	localparam logic FORM_RM_REG     = 1'b1;

	// Opcode match patterns
	localparam logic [7:0] IMM_OPC_MASK = 8'hF0;
	localparam logic [7:0] IMM_OPC_VAL  = 8'hB0;
	localparam logic [7:0] RM_OPC_MASK  = 8'hFC;
	localparam logic [7:0] RM_OPC_VAL   = 8'h88;

	// ModRM mod field codes
	localparam logic [1:0] MOD_MEM_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_MEM_DISP8   = 2'd1;
	localparam logic [1:0] MOD_MEM_DISP16  = 2'd2;
	localparam logic [1:0] MOD_REGISTER    = 2'd3;
	localparam logic [2:0] RM_DIRECT       = 3'b110;

	// Number of displacement bytes that follow a ModRM byte
	function automatic logic [1:0] disp_count(input logic [7:0] modrm);
		logic [1:0] md;
		logic [1:0] cnt;
		md = modrm[7:6];
		case (md)
			MOD_MEM_DISP8:   cnt = 2'd1;
			MOD_MEM_DISP16:  cnt = 2'd2;
			MOD_MEM_NO_DISP: cnt = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			default:         cnt = 2'd0;
		endcase
		return cnt;
	endfunction

	// Record for the immediate-to-register form
	function automatic out_item_t put_imm(input logic [7:0] opc, input logic [15:0] imm);
		out_item_t r;
		r.form               = FORM_IMM_TO_REG;
		r.wide               = opc[3];
		r.reg_is_destination = 1'b1;
		r.reg_code           = opc[2:0];
		r.rm_code            = 3'd0;
		r.mode               = MOD_REGISTER;
		r.direct_address     = 1'b0;
		r.disp_bytes         = 2'd0;
		r.displacement       = 16'd0;
		r.immediate          = imm;
		return r;
	endfunction

	// Record for the register/memory form
	function automatic out_item_t put_rm(input logic [7:0] opc, input logic [7:0] modrm,
			input logic [15:0] disp);
		out_item_t r;
		r.form               = FORM_RM_REG;
		r.wide               = opc[0];
		r.reg_is_destination = opc[1];
		r.reg_code           = modrm[5:3];
		r.rm_code            = modrm[2:0];
		r.mode               = modrm[7:6];
		r.direct_address     = (modrm[7:6] == MOD_MEM_NO_DISP) && (modrm[2:0] == RM_DIRECT);
		r.disp_bytes         = disp_count(modrm);
		r.displacement       = disp;
		r.immediate          = 16'd0;
		return r;
	endfunction

endpackage

@@ hdl/x86_16_mov_instruction_decoder_unit.sv @@
// Top level of the 8086 MOV decoder: input register, parser and result register.
//
// Usage: feed the machine-code stream one byte per transaction on the input
// channel (in_valid/in_ready/in_item). Set end_of_block on the last byte of a
// block; a partly parsed instruction is then dropped and parsing restarts at
// an opcode. Each completed MOV (immediate to register, or reg/mem to/from
// register) yields one record transaction on the output channel
// (out_valid/out_ready/out_item). Other opcode bytes produce nothing.
//
// An accepted byte waits in the input register; if it completes an instruction,
// the record is loaded into the result register at the edge that parses the
// byte out of the input register, and is shown on the output from then on.
// Throughput: one byte per cycle while the result register can take any record
// the byte completes, set by the phase update of the parser between the input register and the result register.
//
// Reset clears both registers' valid flags and returns the parser to the
// opcode phase. When the receiver stalls, the waiting record stays in the
// result register, bytes that complete nothing keep flowing, and one more byte
// is held in the input register before in_ready drops.
module x86_16_mov_instruction_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mdec_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mdec_pkg::out_item_t out_item
);
	import mdec_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      consume;
	logic      emit;
	out_item_t rec;
	logic      out_free;

	// Parse the held byte unless its record has nowhere to go
	assign consume = valid_s1 && (!emit || out_free);

	mdec_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mdec_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.step   (consume),
		.emit   (emit),
		.rec    (rec)
	);

	mdec_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume && emit),
		.rec       (rec),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ hdl/mdec_in_stage.sv @@
// Input register stage: captures one code byte transaction per cycle while empty or while the held byte is consumed.
module mdec_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mdec_pkg::in_item_t in_item,
	input  logic               consume,
	output logic               valid_s1,
	output mdec_pkg::in_item_t item_s1
);
	import mdec_pkg::*;

	// Accept when empty or when the held item leaves this cycle
	assign in_ready = !valid_s1 || consume;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hdl/mdec_parser.sv @@
// Parse state machine: tracks the MOV phase and builds the decoded record.
module mdec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  mdec_pkg::in_item_t  item,
	input  logic                step,
	output logic                emit,
	output mdec_pkg::out_item_t rec
);
	import mdec_pkg::*;

	phase_t     phase_q;
	phase_t     phase_next;
	logic [7:0] opcode_q;
	logic [7:0] modrm_q;
	logic [7:0] low_q;
	logic [7:0] b;

	assign b = item.code_byte;

	// Next phase
	always_comb begin
		case (phase_q)
			PH_IMM_LO:  phase_next = opcode_q[3] ? PH_IMM_HI : PH_OPCODE;
			PH_IMM_HI:  phase_next = PH_OPCODE;
			PH_MODRM:   phase_next = (disp_count(b) == 2'd0) ? PH_OPCODE : PH_DISP_LO;
			PH_DISP_LO: phase_next = (disp_count(modrm_q) == 2'd1) ? PH_OPCODE : PH_DISP_HI;
			PH_DISP_HI: phase_next = PH_OPCODE;
			default: begin
				if ((b & IMM_OPC_MASK) == IMM_OPC_VAL) begin
					phase_next = PH_IMM_LO;
				end else if ((b & RM_OPC_MASK) == RM_OPC_VAL) begin
					phase_next = PH_MODRM;
				end else begin
					phase_next = PH_OPCODE;
				end
			end
		endcase
		if (item.end_of_block) begin
			phase_next = PH_OPCODE;
		end
	end

	// Record and emit flag for the current byte
	always_comb begin
		emit = 1'b0;
		rec  = put_imm(opcode_q, {8'd0, b});
		case (phase_q)
			PH_IMM_LO: begin
				emit = !opcode_q[3];
			end
			PH_IMM_HI: begin
				emit = 1'b1;
				rec  = put_imm(opcode_q, {b, low_q});
			end
			PH_MODRM: begin
				emit = (disp_count(b) == 2'd0);
				rec  = put_rm(opcode_q, b, 16'd0);
			end
			PH_DISP_LO: begin
				emit = (disp_count(modrm_q) == 2'd1);
				rec  = put_rm(opcode_q, modrm_q, {8'd0, b});
			end
			PH_DISP_HI: begin
				emit = 1'b1;
				rec  = put_rm(opcode_q, modrm_q, {b, low_q});
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Advance the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
		end else if (step) begin
			phase_q <= phase_next;
		end
	end

	// Hold the partial fields
	always_ff @(posedge clk) begin
		if (step) begin
			case (phase_q)
				PH_IMM_LO:  low_q <= b;
				PH_MODRM:   modrm_q <= b;
				PH_DISP_LO: low_q <= b;
				PH_IMM_HI, PH_DISP_HI: begin
				end
				default:    opcode_q <= b;
			endcase
		end
	end

endmodule

@@ hdl/mdec_out_stage.sv @@
// Result register: holds one decoded record until the receiver takes it.
module mdec_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mdec_pkg::out_item_t rec,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output mdec_pkg::out_item_t out_item
);
	import mdec_pkg::*;

	// Slot is free when empty or being drained this cycle
	assign free = !out_valid || out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Capture a new record
	always_ff @(posedge clk) begin
		if (load) begin
			out_item <= rec;
		end
	end

endmodule

@@ hdl/mdec_checker.sv @@
// Port-level checker for the MOV decoder, bound to the top level.
module mdec_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input mdec_pkg::out_item_t out_item
);
	import mdec_pkg::*;

	// Hold a stalled record
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled record changed or vanished");

	// Immediate form carries register-mode fields only
	a_imm_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.form == FORM_IMM_TO_REG) |->
			(out_item.mode == MOD_REGISTER) && (out_item.rm_code == 3'd0) &&
			(out_item.disp_bytes == 2'd0) && (out_item.displacement == 16'd0) &&
			out_item.reg_is_destination && !out_item.direct_address &&
			(out_item.wide || (out_item.immediate[15:8] == 8'd0)))
		else $error("malformed immediate record");

	// Reg/mem form flags the direct address exactly
	a_rm_direct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.form == FORM_RM_REG) |->
			(out_item.immediate == 16'd0) &&
			(out_item.direct_address ==
				((out_item.mode == MOD_MEM_NO_DISP) && (out_item.rm_code == RM_DIRECT))))
		else $error("bad direct address flag");

	// Displacement length follows mod and r/m
	a_rm_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.form == FORM_RM_REG) |->
			(out_item.disp_bytes ==
				((out_item.mode == MOD_MEM_DISP8) ? 2'd1 :
				 ((out_item.mode == MOD_MEM_DISP16) || out_item.direct_address) ? 2'd2 :
				 2'd0)) &&
			((out_item.disp_bytes == 2'd2) || (out_item.displacement[15:8] == 8'd0)) &&
			((out_item.disp_bytes != 2'd0) || (out_item.displacement == 16'd0)))
		else $error("displacement length mismatch");

endmodule

bind x86_16_mov_instruction_decoder_unit mdec_checker u_mdec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

@@ bench/mov_record_checker.sv @@
// Channel monitor for the MOV decoder: predicts each decoded record and compares it on arrival.
module mov_record_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mdec_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mdec_pkg::out_item_t out_item,
	output int                  mismatches,
	output int                  records_seen,
	output int                  records_due
);
	import mdec_pkg::*;

	// Parser state as the decoder should hold it
	phase_t     parse_phase;
	logic [7:0] held_opcode;
	logic [7:0] held_modrm;
	logic [7:0] held_low;

	// Records still owed by the block, oldest first
	out_item_t  mov_records[$];
	int         n_bad;
	int         n_checked;

	// Count the displacement bytes that follow a ModRM byte
	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		logic [1:0] len;
		len = 2'd0;
		if (modrm[7:6] == MOD_MEM_DISP8)
			len = 2'd1;
		else if (modrm[7:6] == MOD_MEM_DISP16)
			len = 2'd2;
		else if (modrm[7:6] == MOD_MEM_NO_DISP && modrm[2:0] == RM_DIRECT)
			len = 2'd2;
		return len;
	endfunction

	// Build the record of a MOV immediate to register
	function automatic out_item_t imm_record(input logic [7:0] opc, input logic [15:0] data);
		out_item_t r;
		r = '0;
		r.form               = FORM_IMM_TO_REG;
		r.wide               = opc[3];
		r.reg_is_destination = 1'b1;
		r.reg_code           = opc[2:0];
		r.mode               = MOD_REGISTER;
		r.immediate          = data;
		return r;
	endfunction

	// Build the record of a MOV register/memory to/from register
	function automatic out_item_t rm_record(input logic [7:0] opc, input logic [7:0] modrm,
			input logic [15:0] disp);
		out_item_t r;
		r = '0;
		r.form               = FORM_RM_REG;
		r.wide               = opc[0];
		r.reg_is_destination = opc[1];
		r.reg_code           = modrm[5:3];
		r.rm_code            = modrm[2:0];
		r.mode               = modrm[7:6];
		r.direct_address     = (modrm[7:6] == MOD_MEM_NO_DISP) && (modrm[2:0] == RM_DIRECT);
		r.disp_bytes         = disp_len(modrm);
		r.displacement       = disp;
		return r;
	endfunction

	// Advance the parser by one code byte and queue any completed record
	task automatic decode_byte(input logic [7:0] b, input logic eob);
		case (parse_phase)
			PH_IMM_LO: begin
				if (held_opcode[3]) begin
					held_low = b;
					parse_phase = PH_IMM_HI;
				end else begin
					mov_records.push_back(imm_record(held_opcode, {8'h00, b}));
					parse_phase = PH_OPCODE;
				end
			end
			PH_IMM_HI: begin
				mov_records.push_back(imm_record(held_opcode, {b, held_low}));
				parse_phase = PH_OPCODE;
			end
			PH_MODRM: begin
				held_modrm = b;
				if (disp_len(b) == 2'd0) begin
					mov_records.push_back(rm_record(held_opcode, b, 16'h0000));
					parse_phase = PH_OPCODE;
				end else begin
					parse_phase = PH_DISP_LO;
				end
			end
			PH_DISP_LO: begin
				if (disp_len(held_modrm) == 2'd1) begin
					mov_records.push_back(rm_record(held_opcode, held_modrm, {8'h00, b}));
					parse_phase = PH_OPCODE;
				end else begin
					held_low = b;
					parse_phase = PH_DISP_HI;
				end
			end
			PH_DISP_HI: begin
				mov_records.push_back(rm_record(held_opcode, held_modrm, {b, held_low}));
				parse_phase = PH_OPCODE;
			end
			default: begin
				// Unused phase codes behave as the opcode phase
				if ((b & IMM_OPC_MASK) == IMM_OPC_VAL) begin
					held_opcode = b;
					parse_phase = PH_IMM_LO;
				end else if ((b & RM_OPC_MASK) == RM_OPC_VAL) begin
					held_opcode = b;
					parse_phase = PH_MODRM;
				end else begin
					parse_phase = PH_OPCODE;
				end
			end
		endcase
		// Drop any partial instruction at the end of a block
		if (eob)
			parse_phase = PH_OPCODE;
	endtask

	task automatic match_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_bad++;
		end
	endtask

	// Compare one record transaction against the oldest expectation
	task automatic check_record(input out_item_t got);
		out_item_t want;
		if (mov_records.size() == 0) begin
			$error("record %h arrived with none expected", got);
			n_bad++;
		end else begin
			want = mov_records.pop_front();
			n_checked++;
			match_field("form", want.form, got.form);
			match_field("wide", want.wide, got.wide);
			match_field("reg_is_destination", want.reg_is_destination, got.reg_is_destination);
			match_field("reg_code", want.reg_code, got.reg_code);
			match_field("rm_code", want.rm_code, got.rm_code);
			match_field("mode", want.mode, got.mode);
			match_field("direct_address", want.direct_address, got.direct_address);
			match_field("disp_bytes", want.disp_bytes, got.disp_bytes);
			match_field("displacement", want.displacement, got.displacement);
			match_field("immediate", want.immediate, got.immediate);
		end
	endtask

	// Sample both channels at each edge; check outputs before predicting, since a
	// record never leaves in the cycle its last byte enters
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mov_records.delete();
			parse_phase = PH_OPCODE;
			held_opcode = '0;
			held_modrm = '0;
			held_low = '0;
			n_bad = 0;
			n_checked = 0;
			mismatches <= 0;
			records_seen <= 0;
			records_due <= 0;
		end else begin
			if (out_valid && out_ready)
				check_record(out_item);
			if (in_valid && in_ready)
				decode_byte(in_item.code_byte, in_item.end_of_block);
			mismatches <= n_bad;
			records_seen <= n_checked;
			records_due <= mov_records.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// Top of the MOV decoder bench: clock, reset, code byte stream, receiver stalls and verdict.
module testbench;
	import mdec_pkg::*;

	localparam int STREAM_BYTES = 1850;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 20;

	logic      clk       = 1'b0;
	logic      arst_n;
	logic      in_valid  = 1'b0;
	in_item_t  in_item   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	int mismatches;
	int records_seen;
	int records_due;
	int bytes_sent   = 0;
	int holds_asked  = 0;
	int holds_done   = 0;
	bit sender_calm  = 1'b0;
	bit receiver_calm = 1'b0;

	x86_16_mov_instruction_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	mov_record_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item),
		.mismatches   (mismatches),
		.records_seen (records_seen),
		.records_due  (records_due)
	);

	always #5 clk = ~clk;

	// Offer one code byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic eob);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{code_byte: b, end_of_block: eob};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		if ($urandom_range(0, 59) == 0)
			sender_calm = !sender_calm;
	endtask

	// Drop the input and wait until every expected record has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (records_due != 0)
			@(posedge clk);
	endtask

	// Send one random instruction: mostly well-formed MOVs, some noise, some cut short
	task automatic send_random_instr();
		logic [7:0] bytes[0:3];
		int         pick;
		int         len;
		int         keep;
		bit         broken;
		logic [7:0] modrm;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_byte(8'($urandom), $urandom_range(0, 15) == 0);
		end else begin
			if (pick < 50) begin
				bytes[0] = {4'hB, 4'($urandom)};
				len = bytes[0][3] ? 3 : 2;
			end else begin
				modrm = 8'($urandom);
				if ($urandom_range(0, 5) == 0)
					modrm = {MOD_MEM_NO_DISP, modrm[5:3], RM_DIRECT};
				bytes[0] = {6'b100010, 2'($urandom)};
				bytes[1] = modrm;
				case (modrm[7:6])
					MOD_MEM_DISP8:   len = 3;
					MOD_MEM_DISP16:  len = 4;
					MOD_MEM_NO_DISP: len = (modrm[2:0] == RM_DIRECT) ? 4 : 2;
					default:         len = 2;
				endcase
			end
			for (int i = (pick < 50) ? 1 : 2; i < len; i++)
				bytes[i] = ($urandom_range(0, 7) == 0) ? {8{bytes[0][0]}} : 8'($urandom);
			broken = ($urandom_range(0, 14) == 0);
			keep = broken ? $urandom_range(1, len) : len;
			for (int i = 0; i < keep; i++)
				send_byte(bytes[i], (i == keep - 1) && (broken || $urandom_range(0, 24) == 0));
		end
	endtask

	// Receiver: random stall before each record, plus long hold-offs on request
	initial begin : receiver
		int stall;
		wait (arst_n);
		forever begin
			if (holds_asked > holds_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else begin
				stall = receiver_calm ? 0 : $urandom_range(0, 5);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if ($urandom_range(0, 59) == 0)
				receiver_calm = !receiver_calm;
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Immediate forms at the data extremes
		send_byte(8'hB0, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(8'hBF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		// Register mode with the d bit set and clear
		send_byte(8'h8B, 1'b0); send_byte(8'hC1, 1'b0);
		send_byte(8'h88, 1'b0); send_byte(8'hD8, 1'b0);
		// Direct address takes a 16-bit displacement
		send_byte(8'h88, 1'b0); send_byte(8'h06, 1'b0);
		send_byte(8'h34, 1'b0); send_byte(8'h12, 1'b0);
		// 8-bit and 16-bit displacements
		send_byte(8'h89, 1'b0); send_byte(8'h47, 1'b0); send_byte(8'h80, 1'b0);
		send_byte(8'h8A, 1'b0); send_byte(8'h9F, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		// Unknown opcode next to the reg/mem mask
		send_byte(8'h8C, 1'b0);
		// Block ends mid-instruction, then on a completing byte
		send_byte(8'hB9, 1'b0); send_byte(8'h12, 1'b1);
		send_byte(8'h88, 1'b0); send_byte(8'h3C, 1'b1);

		// Pause the stream until the block has delivered everything
		wait_drained();

		while (bytes_sent < STREAM_BYTES / 2)
			send_random_instr();

		// Long receiver hold-off while short instructions keep coming
		holds_asked++;
		sender_calm = 1'b1;
		for (int i = 0; i < 30; i++) begin
			send_byte({4'hB, 1'b0, 3'($urandom)}, 1'b0);
			send_byte(8'($urandom), 1'b0);
		end
		sender_calm = 1'b0;

		while (bytes_sent < (3 * STREAM_BYTES) / 4)
			send_random_instr();
		wait_drained();
		while (bytes_sent < STREAM_BYTES)
			send_random_instr();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (records_due != 0)
			$error("%0d decoded records never arrived", records_due);
		$display("Sent %0d code bytes, checked %0d MOV records across both forms and all modes,",
			bytes_sent, records_seen);
		$display("with end-of-block cuts, unknown opcodes, random stalls and a long hold-off.");
		if (mismatches == 0 && records_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Run limit
	initial begin : watchdog
		#2000000;
		$display("Timeout: %0d bytes sent, %0d records outstanding", bytes_sent, records_due);
		$display("== FAIL ==");
		$finish;
	end

endmodule
